// File: rtl/mipd_pkg.sv
// Shared types and constants for the minimum-image pair distance block.
`default_nettype none

package mipd_pkg;

    localparam int AXES        = 3;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int FRAC_W      = 40;
    localparam int RED_SHIFT   = 16;
    localparam int RED_W       = FRAC_W - RED_SHIFT;
    localparam int SCALED_W    = RED_W + COORD_W + 1;
    localparam int SQ_LANE_W   = 2 * COORD_W - 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int RSH_W       = REM_W + 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic [COORD_W-1:0] CELL_LEN_RESET = 32'd65536;
    localparam logic [COORD_W-1:0] INV_LEN_RESET  = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_LEN_X = 3'd0,
        REG_CELL_LEN_Y = 3'd1,
        REG_CELL_LEN_Z = 3'd2,
        REG_INV_LEN_X  = 3'd3,
        REG_INV_LEN_Y  = 3'd4,
        REG_INV_LEN_Z  = 3'd5
    } reg_index_t;

    typedef logic [AXES-1:0][COORD_W-1:0] axis_vec_t;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_z;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [COORD_W-1:0] second_z;
    } pair_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] disp_x;
        logic signed [COORD_W-1:0] disp_y;
        logic signed [COORD_W-1:0] disp_z;
        logic [SQ_W-1:0]           dist_squared;
        logic [ROOT_W-1:0]         dist_res;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/mipd_pair_if.sv
// Stream interface carrying one particle pair per transaction.
`default_nettype none

interface mipd_pair_if;
    logic            valid;
    logic            ready;
    mipd_pkg::pair_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mipd_result_if.sv
// Stream interface carrying one displacement and distance result per transaction.
`default_nettype none

interface mipd_result_if;
    logic              valid;
    logic              ready;
    mipd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/min_image_pair_distance.sv
// Top level of the minimum-image pair distance pipeline.
//
// Usage: each transaction on the pair channel carries two particle positions
// (Q16.16). Each one gives exactly one transaction on the result channel,
// in order: minimum-image displacement first minus second per axis (Q16.16
// signed), squared distance (Q32.32) and floor of the distance (Q16.16).
// The user writes cell lengths and reciprocals through cfg_we/cfg_index/cfg_data
// only while no pair is in flight (not enforced); unknown indexes are ignored.
// Throughput: one pair per clock unless held. A pair passes 3 stages of
// scale/wrap/scale-back, 2 of squaring and sum, 32 of the bit-per-stage
// square root, then the output register, before its result is valid.
// Reset empties the pipeline and sets every length and reciprocal to 1.0.
// When the receiver stalls, the pipeline keeps moving until one finished
// result waits in the output register and one in a skid register; then the
// whole pipeline holds and pair.ready drops until the skid register drains.
`default_nettype none

module min_image_pair_distance (
    input  logic                              clk,
    input  logic                              rst_n,
    mipd_pair_if.sink                         pair,
    mipd_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [mipd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mipd_pkg::COORD_W-1:0]      cfg_data
);

    mipd_pkg::axis_vec_t cell_len_reg;
    mipd_pkg::axis_vec_t inv_len_reg;

    logic                             en;
    logic                             disp_valid;
    mipd_pkg::axis_vec_t              disp_w;
    logic                             sq_valid;
    mipd_pkg::axis_vec_t              sq_disp;
    logic [mipd_pkg::SQ_W-1:0]        sq_sum;
    logic                             tail_valid;
    mipd_pkg::axis_vec_t              tail_disp;
    logic [mipd_pkg::SQ_W-1:0]        tail_sq;
    logic [mipd_pkg::ROOT_W-1:0]      tail_root;
    mipd_pkg::result_t                tail;

    logic                             out_valid_reg;
    mipd_pkg::result_t                out_data_reg;
    logic                             skid_valid_reg;
    mipd_pkg::result_t                skid_data_reg;
    logic                             out_free;

    // whole pipeline moves unless the skid register is occupied
    assign en         = !skid_valid_reg;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mipd_pkg::AXES; i++)
            begin
                cell_len_reg[i] <= mipd_pkg::CELL_LEN_RESET;
                inv_len_reg[i]  <= mipd_pkg::INV_LEN_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mipd_pkg::REG_CELL_LEN_X: cell_len_reg[0] <= cfg_data;
                mipd_pkg::REG_CELL_LEN_Y: cell_len_reg[1] <= cfg_data;
                mipd_pkg::REG_CELL_LEN_Z: cell_len_reg[2] <= cfg_data;
                mipd_pkg::REG_INV_LEN_X:  inv_len_reg[0]  <= cfg_data;
                mipd_pkg::REG_INV_LEN_Y:  inv_len_reg[1]  <= cfg_data;
                mipd_pkg::REG_INV_LEN_Z:  inv_len_reg[2]  <= cfg_data;
                default: ;
            endcase
        end
    end

    mipd_disp u_disp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair.valid),
        .pair      (pair.data),
        .cell_len  (cell_len_reg),
        .inv_len   (inv_len_reg),
        .out_valid (disp_valid),
        .disp      (disp_w)
    );

    mipd_sumsq u_sumsq (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (disp_valid),
        .disp         (disp_w),
        .out_valid    (sq_valid),
        .disp_out     (sq_disp),
        .dist_squared (sq_sum)
    );

    mipd_isqrt u_isqrt (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (sq_valid),
        .disp             (sq_disp),
        .dist_squared     (sq_sum),
        .out_valid        (tail_valid),
        .disp_out         (tail_disp),
        .dist_squared_out (tail_sq),
        .dist_res         (tail_root)
    );

    always_comb
    begin
        tail.disp_x       = tail_disp[0];
        tail.disp_y       = tail_disp[1];
        tail.disp_z       = tail_disp[2];
        tail.dist_squared = tail_sq;
        tail.dist_res     = tail_root;
    end

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tail_valid;
            end
        end
        else if (tail_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : tail;
        end
        if (!out_free && en)
        begin
            skid_data_reg <= tail;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // skid register only fills while a result is held at the output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid register filled without an output stall");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds data while output is empty");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (mipd_pkg::SQ_W'(result.data.dist_res)
                          * mipd_pkg::SQ_W'(result.data.dist_res)
                          <= result.data.dist_squared))
        else $error("distance root exceeds square root of squared distance");

endmodule

`default_nettype wire

// File: rtl/mipd_disp.sv
// Three-stage per-axis minimum-image displacement: scale, wrap, scale back.
`default_nettype none

module mipd_disp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mipd_pkg::pair_t     pair,
    input  mipd_pkg::axis_vec_t cell_len,
    input  mipd_pkg::axis_vec_t inv_len,
    output logic                out_valid,
    output mipd_pkg::axis_vec_t disp
);

    mipd_pkg::axis_vec_t first_w;
    mipd_pkg::axis_vec_t second_w;

    logic [mipd_pkg::AXES-1:0][mipd_pkg::PROD_W-1:0] prod_a;
    logic [mipd_pkg::AXES-1:0][mipd_pkg::PROD_W-1:0] prod_b;
    logic [mipd_pkg::AXES-1:0][mipd_pkg::FRAC_W-1:0] sa_reg;
    logic [mipd_pkg::AXES-1:0][mipd_pkg::FRAC_W-1:0] sb_reg;
    logic [mipd_pkg::AXES-1:0][mipd_pkg::FRAC_W-1:0] diff;
    logic [mipd_pkg::AXES-1:0][mipd_pkg::RED_W-1:0]  red_reg;
    logic signed [mipd_pkg::SCALED_W-1:0]           scaled [mipd_pkg::AXES];
    mipd_pkg::axis_vec_t                             disp_reg;
    logic [2:0]                                      vld_reg;

    assign first_w  = {pair.first_z, pair.first_y, pair.first_x};
    assign second_w = {pair.second_z, pair.second_y, pair.second_x};

    always_comb
    begin
        for (int i = 0; i < mipd_pkg::AXES; i++)
        begin
            prod_a[i] = mipd_pkg::PROD_W'(first_w[i]) * mipd_pkg::PROD_W'(inv_len[i]);
            prod_b[i] = mipd_pkg::PROD_W'(second_w[i]) * mipd_pkg::PROD_W'(inv_len[i]);
            // modulo 2^40 the difference is already the wrapped signed fraction
            diff[i]   = sa_reg[i] - sb_reg[i];
            scaled[i] = mipd_pkg::SCALED_W'($signed(red_reg[i]))
                      * mipd_pkg::SCALED_W'($signed({1'b0, cell_len[i]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < mipd_pkg::AXES; i++)
            begin
                sa_reg[i]   <= prod_a[i][mipd_pkg::FRAC_W-1:0];
                sb_reg[i]   <= prod_b[i][mipd_pkg::FRAC_W-1:0];
                red_reg[i]  <= diff[i][mipd_pkg::FRAC_W-1:mipd_pkg::RED_SHIFT];
                disp_reg[i] <= scaled[i][mipd_pkg::SCALED_W-2:mipd_pkg::RED_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign disp      = disp_reg;

endmodule

`default_nettype wire

// File: rtl/mipd_sumsq.sv
// Two-stage squared distance: per-axis squares, then their sum.
`default_nettype none

module mipd_sumsq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  mipd_pkg::axis_vec_t           disp,
    output logic                          out_valid,
    output mipd_pkg::axis_vec_t           disp_out,
    output logic [mipd_pkg::SQ_W-1:0]     dist_squared
);

    logic signed [mipd_pkg::SQ_W-1:0]                   sq_full [mipd_pkg::AXES];
    logic [mipd_pkg::AXES-1:0][mipd_pkg::SQ_LANE_W-1:0] sq_reg;
    mipd_pkg::axis_vec_t                                disp_a_reg;
    mipd_pkg::axis_vec_t                                disp_b_reg;
    logic [mipd_pkg::SQ_W-1:0]                          sum_reg;
    logic [1:0]                                         vld_reg;

    always_comb
    begin
        for (int i = 0; i < mipd_pkg::AXES; i++)
        begin
            sq_full[i] = mipd_pkg::SQ_W'($signed(disp[i])) * mipd_pkg::SQ_W'($signed(disp[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < mipd_pkg::AXES; i++)
            begin
                // a square of a 32-bit value is at most 2^62
                sq_reg[i] <= sq_full[i][mipd_pkg::SQ_LANE_W-1:0];
            end
            disp_a_reg <= disp;
            sum_reg    <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
            disp_b_reg <= disp_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    assign out_valid    = vld_reg[1];
    assign disp_out     = disp_b_reg;
    assign dist_squared = sum_reg;

endmodule

`default_nettype wire

// File: rtl/mipd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module mipd_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  mipd_pkg::axis_vec_t           disp,
    input  logic [mipd_pkg::SQ_W-1:0]     dist_squared,
    output logic                          out_valid,
    output mipd_pkg::axis_vec_t           disp_out,
    output logic [mipd_pkg::SQ_W-1:0]     dist_squared_out,
    output logic [mipd_pkg::ROOT_W-1:0]   dist_res
);

    localparam int N = mipd_pkg::SQRT_STAGES;

    logic [mipd_pkg::REM_W-1:0]  rem_reg   [N];
    logic [mipd_pkg::ROOT_W-1:0] root_reg  [N];
    logic [mipd_pkg::SQ_W-1:0]   val_reg   [N];
    mipd_pkg::axis_vec_t         disp_reg  [N];
    logic [N-1:0]                vld_reg;

    logic [mipd_pkg::REM_W-1:0]  rem_prev  [N];
    logic [mipd_pkg::ROOT_W-1:0] root_prev [N];
    logic [mipd_pkg::SQ_W-1:0]   val_prev  [N];
    mipd_pkg::axis_vec_t         disp_prev [N];
    logic [mipd_pkg::RSH_W-1:0]  r_sh      [N];
    logic [mipd_pkg::RSH_W-1:0]  trial     [N];
    logic [mipd_pkg::RSH_W:0]    diff      [N];
    logic [mipd_pkg::REM_W-1:0]  rem_next  [N];
    logic [mipd_pkg::ROOT_W-1:0] root_next [N];

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            if (j == 0)
            begin
                rem_prev[j]  = '0;
                root_prev[j] = '0;
                val_prev[j]  = dist_squared;
                disp_prev[j] = disp;
            end
            else
            begin
                rem_prev[j]  = rem_reg[j-1];
                root_prev[j] = root_reg[j-1];
                val_prev[j]  = val_reg[j-1];
                disp_prev[j] = disp_reg[j-1];
            end
            // bring down the next radicand digit pair, most significant first
            r_sh[j]  = {rem_prev[j], val_prev[j][mipd_pkg::SQ_W-1-2*j -: 2]};
            trial[j] = {2'b00, root_prev[j], 2'b01};
            diff[j]  = {1'b0, r_sh[j]} - {1'b0, trial[j]};
            if (!diff[j][mipd_pkg::RSH_W])
            begin
                rem_next[j]  = diff[j][mipd_pkg::REM_W-1:0];
                root_next[j] = {root_prev[j][mipd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = r_sh[j][mipd_pkg::REM_W-1:0];
                root_next[j] = {root_prev[j][mipd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < N; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                val_reg[j]  <= val_prev[j];
                disp_reg[j] <= disp_prev[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    assign out_valid        = vld_reg[N-1];
    assign disp_out         = disp_reg[N-1];
    assign dist_squared_out = val_reg[N-1];
    assign dist_res         = root_reg[N-1];

endmodule

`default_nettype wire

// File: tb/mipd_checker.sv
// Checker for the minimum-image pair distance block: predicts and compares every result.
module mipd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    mipd_pair_if                           pair,
    mipd_result_if                         result,
    input  logic                           cfg_we,
    input  logic [mipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mipd_pkg::COORD_W-1:0]   cfg_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mipd_pkg::COORD_W-1:0] edge_q16  [mipd_pkg::AXES];
    logic [mipd_pkg::COORD_W-1:0] recip_q24 [mipd_pkg::AXES];
    mipd_pkg::result_t            want_q[$];
    mipd_pkg::result_t            want;
    int                           fail_count = 0;

    // Displacement a - b along one axis, wrapped to the nearest image, Q16.16.
    function automatic logic signed [mipd_pkg::COORD_W-1:0] wrapped_axis(
        input logic [mipd_pkg::COORD_W-1:0] a,
        input logic [mipd_pkg::COORD_W-1:0] b,
        input logic [mipd_pkg::COORD_W-1:0] len,
        input logic [mipd_pkg::COORD_W-1:0] recip
    );
        logic [63:0] diff;
        longint      reduced;
        longint      scaled;
        diff    = {32'b0, a} * {32'b0, recip} - {32'b0, b} * {32'b0, recip};
        // low 40 bits read as signed are the fraction in [-0.5, 0.5); keep Q0.24
        reduced = longint'($signed(diff[39:16]));
        scaled  = reduced * longint'({32'b0, len});
        return mipd_pkg::COORD_W'(scaled >>> 24);
    endfunction

    function automatic logic [mipd_pkg::ROOT_W-1:0] floor_root(
        input logic [mipd_pkg::SQ_W-1:0] v
    );
        logic [mipd_pkg::ROOT_W-1:0] root;
        logic [mipd_pkg::ROOT_W-1:0] trial;
        root = '0;
        for (int b = mipd_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (mipd_pkg::ROOT_W'(1) << b);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic mipd_pkg::result_t min_image_of(input mipd_pkg::pair_t p);
        mipd_pkg::result_t                   r;
        logic signed [mipd_pkg::COORD_W-1:0] d [mipd_pkg::AXES];
        logic [mipd_pkg::SQ_W-1:0]           mag;
        logic [mipd_pkg::SQ_W-1:0]           sum;
        d[0] = wrapped_axis(p.first_x, p.second_x, edge_q16[0], recip_q24[0]);
        d[1] = wrapped_axis(p.first_y, p.second_y, edge_q16[1], recip_q24[1]);
        d[2] = wrapped_axis(p.first_z, p.second_z, edge_q16[2], recip_q24[2]);
        sum  = '0;
        for (int i = 0; i < mipd_pkg::AXES; i++)
        begin
            mag = (d[i] < 0) ? 64'(-longint'(d[i])) : 64'(longint'(d[i]));
            sum = sum + mag * mag;
        end
        r.disp_x       = d[0];
        r.disp_y       = d[1];
        r.disp_z       = d[2];
        r.dist_squared = sum;
        r.dist_res     = floor_root(sum);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mipd_pkg::AXES; i++)
            begin
                edge_q16[i]  = mipd_pkg::CELL_LEN_RESET;
                recip_q24[i] = mipd_pkg::INV_LEN_RESET;
            end
            want_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mipd_pkg::REG_CELL_LEN_X: edge_q16[0]  = cfg_data;
                    mipd_pkg::REG_CELL_LEN_Y: edge_q16[1]  = cfg_data;
                    mipd_pkg::REG_CELL_LEN_Z: edge_q16[2]  = cfg_data;
                    mipd_pkg::REG_INV_LEN_X:  recip_q24[0] = cfg_data;
                    mipd_pkg::REG_INV_LEN_Y:  recip_q24[1] = cfg_data;
                    mipd_pkg::REG_INV_LEN_Z:  recip_q24[2] = cfg_data;
                    default: ;
                endcase
            end
            if (pair.valid && pair.ready)
                want_q.push_back(min_image_of(pair.data));
            if (result.valid && result.ready)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, result.data);
                    fail_count++;
                end
                else
                begin
                    want = want_q.pop_front();
                    check_field("disp_x", 64'(want.disp_x), 64'(result.data.disp_x));
                    check_field("disp_y", 64'(want.disp_y), 64'(result.data.disp_y));
                    check_field("disp_z", 64'(want.disp_z), 64'(result.data.disp_z));
                    check_field("dist_squared", want.dist_squared,
                                result.data.dist_squared);
                    check_field("dist_res", 64'(want.dist_res), 64'(result.data.dist_res));
                end
            end
        end
        pending <= want_q.size();
        errors  <= fail_count;
    end

endmodule

// File: tb/tb_top.sv
// Top of the minimum-image pair distance testbench: stimulus, idling and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG     = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN        = 48;
    localparam int PER_SETTING  = 100;
    localparam int SETTINGS_PER = 4;

    // indexes past the last register; writes there must be ignored
    localparam logic [mipd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [mipd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [mipd_pkg::COORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [mipd_pkg::COORD_W-1:0] HALF     = 32'h0000_8000;

    logic                           clk   = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [mipd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mipd_pkg::COORD_W-1:0]   cfg_data;
    int                             errors;
    int                             pending;

    int                             send_idle  = 23;
    int                             recv_idle  = 60;
    logic                           stall_req  = 1'b0;
    logic                           stall_done = 1'b0;
    int                             stall_left = 0;
    int                             quiet      = 0;
    logic [mipd_pkg::COORD_W-1:0]   cur_len [mipd_pkg::AXES];

    mipd_pair_if   pair_ch ();
    mipd_result_if res_ch ();

    min_image_pair_distance DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mipd_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stall_req && !stall_done)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= HOLD_CYCLES;
            stall_done   <= 1'b1;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic put_reg(input logic [mipd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mipd_pkg::COORD_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic load_cell(input logic [mipd_pkg::COORD_W-1:0] lx, ly, lz, ix, iy, iz);
        put_reg(mipd_pkg::REG_CELL_LEN_X, lx);
        put_reg(mipd_pkg::REG_CELL_LEN_Y, ly);
        put_reg(REG_SPARE_6, $urandom);
        put_reg(mipd_pkg::REG_CELL_LEN_Z, lz);
        put_reg(mipd_pkg::REG_INV_LEN_X, ix);
        put_reg(mipd_pkg::REG_INV_LEN_Y, iy);
        put_reg(mipd_pkg::REG_INV_LEN_Z, iz);
        put_reg(REG_SPARE_7, $urandom);
        cfg_we     <= 1'b0;
        cur_len[0] = lx;
        cur_len[1] = ly;
        cur_len[2] = lz;
    endtask

    // Drop valid and wait until every transaction in flight has come out.
    task automatic settle();
        pair_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic send_pair(input mipd_pkg::pair_t p);
        while ($urandom_range(0, 99) < send_idle)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        do
            @(posedge clk);
        while (!pair_ch.ready);
    endtask

    task automatic send_coords(input logic [mipd_pkg::COORD_W-1:0] fx, fy, fz, sx, sy, sz);
        mipd_pkg::pair_t p;
        p.first_x  = fx;
        p.first_y  = fy;
        p.first_z  = fz;
        p.second_x = sx;
        p.second_y = sy;
        p.second_z = sz;
        send_pair(p);
    endtask

    function automatic logic [mipd_pkg::COORD_W-1:0] pick_coord();
        logic [mipd_pkg::COORD_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = mipd_pkg::COORD_W'($urandom_range(0, 32'h0000_FFFF));
            1:       c = ALL_ONES - mipd_pkg::COORD_W'($urandom_range(0, 32'h0000_FFFF));
            2:       c = $urandom_range(0, 1) ? ALL_ONES : '0;
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // Second coordinate: often close to the first or about half a cell away.
    function automatic logic [mipd_pkg::COORD_W-1:0] partner(
        input logic [mipd_pkg::COORD_W-1:0] a,
        input logic [mipd_pkg::COORD_W-1:0] len
    );
        logic [mipd_pkg::COORD_W-1:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = a + mipd_pkg::COORD_W'($urandom_range(0, 32'h0002_0000))
                         - 32'h0001_0000;
            2:       c = a + (len >> 1) + mipd_pkg::COORD_W'($urandom_range(0, 8)) - 32'd4;
            3:       c = a - (len >> 1) + mipd_pkg::COORD_W'($urandom_range(0, 8)) - 32'd4;
            default: c = pick_coord();
        endcase
        return c;
    endfunction

    function automatic mipd_pkg::pair_t random_pair();
        mipd_pkg::pair_t p;
        p.first_x  = pick_coord();
        p.first_y  = pick_coord();
        p.first_z  = pick_coord();
        p.second_x = partner(p.first_x, cur_len[0]);
        p.second_y = partner(p.first_y, cur_len[1]);
        p.second_z = partner(p.first_z, cur_len[2]);
        return p;
    endfunction

    task automatic load_setting(input int k);
        logic [mipd_pkg::COORD_W-1:0] len [mipd_pkg::AXES];
        logic [mipd_pkg::COORD_W-1:0] rcp [mipd_pkg::AXES];
        for (int i = 0; i < mipd_pkg::AXES; i++)
        begin
            case (k)
                0:
                begin
                    // consistent pair, wide range of cell sizes
                    len[i] = mipd_pkg::COORD_W'($urandom_range(32'h0000_4000, ALL_ONES));
                    rcp[i] = mipd_pkg::COORD_W'((64'd1 << 40) / len[i]);
                end
                1:
                begin
                    len[i] = $urandom;
                    rcp[i] = $urandom;
                end
                2:
                begin
                    len[i] = mipd_pkg::COORD_W'($urandom_range(32'h0000_8000,
                                                                32'h0010_0000));
                    rcp[i] = mipd_pkg::COORD_W'((64'd1 << 40) / len[i]);
                end
                default:
                begin
                    len[i] = $urandom_range(0, 1) ? ALL_ONES : 32'd1;
                    rcp[i] = $urandom_range(0, 1) ? ALL_ONES : 32'd1;
                end
            endcase
        end
        load_cell(len[0], len[1], len[2], rcp[0], rcp[1], rcp[2]);
    endtask

    initial
    begin
        pair_ch.valid = 1'b0;
        pair_ch.data  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_len[0]    = mipd_pkg::CELL_LEN_RESET;
        cur_len[1]    = mipd_pkg::CELL_LEN_RESET;
        cur_len[2]    = mipd_pkg::CELL_LEN_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset cell of 1.0: extremes, exact half-cell wrap and its neighbours
        send_coords('0, '0, '0, '0, '0, '0);
        send_coords(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_coords(ALL_ONES, ALL_ONES, ALL_ONES, '0, '0, '0);
        send_coords('0, '0, '0, ALL_ONES, ALL_ONES, ALL_ONES);
        send_coords(HALF, '0, HALF, '0, HALF, '0);
        send_coords(HALF - 1, HALF + 1, '0, '0, '0, HALF - 1);
        send_coords(32'h0005_4000, 32'h0001_0000, 32'h7FFF_0000,
                    32'h0001_0000, 32'h0005_C000, 32'h8000_8000);
        send_coords(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

        // largest lengths and reciprocals
        settle();
        load_cell(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_coords(ALL_ONES, '0, 32'h1234_5678, '0, ALL_ONES, 32'h8765_4321);
        send_coords(32'h5555_5555, 32'hAAAA_AAAA, 32'd1, 32'hAAAA_AAAA, 32'h5555_5555, '0);

        // smallest lengths and reciprocals
        settle();
        load_cell(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
        send_coords(ALL_ONES, '0, HALF, '0, ALL_ONES, '0);
        send_coords(32'h8000_0000, 32'h7FFF_FFFF, ALL_ONES, '0, 32'h8000_0000, 32'd1);

        // zero length on x, zero reciprocal on y, a long cell on z
        settle();
        load_cell('0, 32'h0001_0000, 32'h0100_0000, 32'h0100_0000, '0, 32'h0001_0000);
        send_coords(32'h0000_C000, 32'h1234_5678, 32'h00FF_0000,
                    '0, 32'h8765_4321, '0);
        send_coords(ALL_ONES, ALL_ONES, '0, '0, '0, ALL_ONES);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 23;
                    recv_idle <= 60;
                end
                1:
                begin
                    send_idle = 60;
                    recv_idle <= 23;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle <= 0;
                end
            endcase
            for (int k = 0; k < SETTINGS_PER; k++)
            begin
                settle();
                load_setting(k);
                if (ph == 2 && k == 1)
                    stall_req <= 1'b1;
                repeat (PER_SETTING)
                    send_pair(random_pair());
            end
        end

        settle();
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
